>>> design/scbc_pkg.sv
// Shared constants, types and helper functions for the size-class block cache.
`timescale 1ns / 1ps
`default_nettype none

package scbc_pkg;

	// Cache geometry.
	localparam int NUM_STREAMS = 8;
	localparam int NUM_CLASSES = 41;
	localparam int LIST_DEPTH  = 16;
	localparam int ADDR_BITS   = 48;

	// Field widths of the request and response words.
	localparam int OP_W     = 2;
	localparam int BYTES_W  = 41;
	localparam int SID_W    = 3;
	localparam int ADDR_W   = 48;
	localparam int STATUS_W = 4;
	localparam int MISS_W   = 63;

	// The largest class that a power of two still fits in the size field.
	localparam int MAX_CLASS_BY_WIDTH = 40;
	localparam int CLASS_W            = 6;

	// Derived sizes.
	localparam int NUM_LISTS   = NUM_STREAMS * NUM_CLASSES;
	localparam int FILL_W      = $clog2(LIST_DEPTH + 1);
	localparam int STREAM_W    = (NUM_STREAMS > 1) ? $clog2(NUM_STREAMS) : 1;
	localparam int LIST_W      = $clog2(NUM_LISTS);
	localparam int ROW_W       = NUM_CLASSES * FILL_W;
	localparam int STORE_DEPTH = NUM_LISTS * LIST_DEPTH;
	localparam int STORE_AW    = $clog2(STORE_DEPTH);

	localparam logic [ADDR_W-1:0] ADDR_MASK = (ADDR_BITS >= ADDR_W) ? {ADDR_W{1'b1}} :
		ADDR_W'((64'd1 << ADDR_BITS) - 64'd1);
	localparam logic [MISS_W-1:0] MISS_MAX  = {MISS_W{1'b1}};
	localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(LIST_DEPTH);

	// Request operations.
	typedef enum logic [OP_W-1:0] {
		OP_ALLOC    = 2'd0,
		OP_FREE     = 2'd1,
		OP_DRAIN    = 2'd2,
		OP_MISS_CLR = 2'd3
	} op_t;

	// Response status codes.
	typedef enum logic [STATUS_W-1:0] {
		RS_HIT       = 4'd0,
		RS_MISS      = 4'd1,
		RS_ZERO      = 4'd2,
		RS_TOO_LARGE = 4'd3,
		RS_STORED    = 4'd4,
		RS_NULL      = 4'd5,
		RS_DROPPED   = 4'd6,
		RS_DRAINED   = 4'd7,
		RS_EMPTY     = 4'd8,
		RS_MISS_CLR  = 4'd9
	} status_t;

	// Sequencer states.
	typedef enum logic [1:0] {
		S_IDLE,
		S_ROW,
		S_POP,
		S_HOLD
	} state_t;

	// Size class: ceil(log2(n)), with sizes zero and one in class zero.
	function automatic logic [CLASS_W-1:0] size_class(input logic [BYTES_W-1:0] n);
		logic [BYTES_W-1:0] v;
		logic [CLASS_W-1:0] c;
		v = n - BYTES_W'(1);
		c = '0;
		if (n > BYTES_W'(1)) begin
			for (int i = 0; i < BYTES_W; i++) begin
				if (v[i]) begin
					c = CLASS_W'(i + 1);
				end
			end
		end
		return c;
	endfunction

	// A class is usable when it has a list and its power of two fits the size field.
	function automatic logic class_ok(input logic [CLASS_W-1:0] c);
		return (int'(c) < NUM_CLASSES) && (int'(c) <= MAX_CLASS_BY_WIDTH);
	endfunction

	// Stream id reduced modulo the number of streams by repeated subtraction.
	function automatic logic [STREAM_W-1:0] stream_fold(input logic [SID_W-1:0] sid);
		logic [SID_W-1:0] v;
		v = sid;
		for (int i = 0; i < (1 << SID_W); i++) begin
			if (int'(v) >= NUM_STREAMS) begin
				v = v - SID_W'(NUM_STREAMS);
			end
		end
		return STREAM_W'(v);
	endfunction

endpackage

`default_nettype wire

>>> design/scbc_req_if.sv
// Request channel interface of the size-class block cache.
`timescale 1ns / 1ps
`default_nettype none

interface scbc_req_if import scbc_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [OP_W-1:0]    op;
	logic [BYTES_W-1:0] request_bytes;
	logic [SID_W-1:0]   stream_id;
	logic [ADDR_W-1:0]  block_address;

	modport source (output valid, output op, output request_bytes, output stream_id,
		output block_address, input ready);
	modport sink (input valid, input op, input request_bytes, input stream_id,
		input block_address, output ready);
endinterface

`default_nettype wire

>>> design/scbc_rsp_if.sv
// Response channel interface of the size-class block cache.
`timescale 1ns / 1ps
`default_nettype none

interface scbc_rsp_if import scbc_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [ADDR_W-1:0]   block_address_res;
	logic [BYTES_W-1:0]  alloc_bytes;
	logic [MISS_W-1:0]   miss_count;
	logic                cache_empty;

	modport source (output valid, output status, output block_address_res,
		output alloc_bytes, output miss_count, output cache_empty, input ready);
	modport sink (input valid, input status, input block_address_res,
		input alloc_bytes, input miss_count, input cache_empty, output ready);
endinterface

`default_nettype wire

>>> design/size_class_block_cache.sv
// Top level of the size-class block cache: sequencer, fill rows and address store.
//
// The block keeps freed blocks in last-in first-out lists, one per stream and
// power-of-two size class. Requests arrive as words on the req channel
// (allocate, free, drain one block, clear the miss counter); each request gives
// exactly one response word on the rsp channel, in request order.
// The fill counts of all classes of one stream sit in one row of a small RAM,
// and the cached addresses sit in a second RAM of one slot per list entry.
// A request is taken only while the sequencer is idle. Its fill row is read at
// acceptance and updated in the next cycle, in S_ROW; allocate hits and drains
// that return a block then read the address store in a further state, S_POP.
// A response is loaded into the output register from S_ROW, or from S_POP for
// a hit or for such a drain, and the block cannot take a new request before
// the last one has left the sequencer.
// The output register lets the next request start while a response still
// waits; if the receiver stalls, the finished result is parked and the block
// takes no new request until it has gone out.
// Reset clears the per-stream occupancy flags, the miss counter and the
// handshake state at once; no clearing pass runs over the RAMs, as a fill row
// of a stream whose flag is low reads as empty.
`timescale 1ns / 1ps
`default_nettype none

module size_class_block_cache import scbc_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	scbc_req_if.sink  req,
	scbc_rsp_if.source rsp
);

	// Sequencer and request registers.
	state_t                state_q, state_d;
	op_t                   op_q;
	logic                  bytes_zero_q;
	logic [CLASS_W-1:0]    cls_q;
	logic                  cls_ok_q;
	logic [STREAM_W-1:0]   stream_q;
	logic [ADDR_W-1:0]     addr_q;
	logic                  drain_any_q;

	// Architectural state outside the RAMs.
	logic [NUM_STREAMS-1:0] summary_q, summary_d;
	logic [MISS_W-1:0]      misses_q, misses_d;

	// Parked result.
	status_t               res_status_q;
	logic [ADDR_W-1:0]     res_addr_q;
	logic [BYTES_W-1:0]    res_bytes_q;
	logic                  res_we;
	logic                  res_addr_we;
	logic [ADDR_W-1:0]     res_addr_d;

	// Output register.
	logic                  out_valid_q;
	status_t               out_status_q;
	logic [ADDR_W-1:0]     out_addr_q;
	logic [BYTES_W-1:0]    out_bytes_q;
	logic [MISS_W-1:0]     out_miss_q;
	logic                  out_empty_q;
	logic                  out_free;
	logic                  out_load;
	status_t               out_status_d;
	logic [ADDR_W-1:0]     out_addr_d;
	logic [BYTES_W-1:0]    out_bytes_d;
	logic [MISS_W-1:0]     out_miss_d;
	logic                  out_empty_d;

	// Request decode at acceptance.
	logic                  accept;
	op_t                   req_op;
	logic [STREAM_W-1:0]   drain_stream;
	logic [STREAM_W-1:0]   acc_stream;

	// Fill row RAM.
	logic                  fill_we;
	logic [ROW_W-1:0]      fill_rdata;
	logic [ROW_W-1:0]      row_eff;
	logic [ROW_W-1:0]      row_new;

	// Address store RAM.
	logic                  store_we;
	logic                  store_re;
	logic [STORE_AW-1:0]   store_waddr;
	logic [STORE_AW-1:0]   store_raddr;
	logic [ADDR_W-1:0]     store_rdata;

	// List update terms.
	logic [NUM_CLASSES-1:0] cls_nz;
	logic [CLASS_W-1:0]    drain_cls;
	logic [CLASS_W-1:0]    sel_cls;
	logic [FILL_W-1:0]     sel_fill;
	logic [FILL_W-1:0]     new_fill;
	logic [LIST_W-1:0]     list_idx;
	logic [STORE_AW-1:0]   list_base;
	logic                  pop;
	logic                  row_upd;
	status_t               r_status;
	logic [BYTES_W-1:0]    r_bytes;

	// Handshake.
	assign req.ready = (state_q == S_IDLE);
	assign accept    = req.valid && req.ready;
	assign req_op    = op_t'(req.op);
	assign out_free  = !out_valid_q || rsp.ready;

	// Lowest stream that holds a block, for drains.
	always_comb begin
		drain_stream = '0;
		for (int i = NUM_STREAMS - 1; i >= 0; i--) begin
			if (summary_q[i]) begin
				drain_stream = STREAM_W'(i);
			end
		end
		acc_stream = (req_op == OP_DRAIN) ? drain_stream : stream_fold(req.stream_id);
	end

	// Request fields are captured at acceptance.
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q         <= req_op;
			bytes_zero_q <= (req.request_bytes == '0);
			cls_q        <= size_class(req.request_bytes);
			cls_ok_q     <= class_ok(size_class(req.request_bytes));
			stream_q     <= acc_stream;
			addr_q       <= req.block_address & ADDR_MASK;
			drain_any_q  <= |summary_q;
		end
	end

	// Fill counts of all classes of one stream, one row per stream.
	scbc_ram #(
		.WIDTH (ROW_W),
		.DEPTH (NUM_STREAMS)
	) u_fill_ram (
		.clk   (clk),
		.we    (fill_we),
		.waddr (stream_q),
		.wdata (row_new),
		.re    (accept),
		.raddr (acc_stream),
		.rdata (fill_rdata)
	);

	// Cached block addresses, one slot per list entry.
	scbc_ram #(
		.WIDTH (ADDR_W),
		.DEPTH (STORE_DEPTH)
	) u_store_ram (
		.clk   (clk),
		.we    (store_we),
		.waddr (store_waddr),
		.wdata (addr_q),
		.re    (store_re),
		.raddr (store_raddr),
		.rdata (store_rdata)
	);

	// Selected list and its fill count.
	always_comb begin
		row_eff = summary_q[stream_q] ? fill_rdata : '0;
		for (int c = 0; c < NUM_CLASSES; c++) begin
			cls_nz[c] = |row_eff[c*FILL_W +: FILL_W];
		end
		drain_cls = '0;
		for (int c = NUM_CLASSES - 1; c >= 0; c--) begin
			if (cls_nz[c]) begin
				drain_cls = CLASS_W'(c);
			end
		end
		sel_cls     = (op_q == OP_DRAIN) ? drain_cls : cls_q;
		sel_fill    = row_eff[int'(sel_cls)*FILL_W +: FILL_W];
		list_idx    = LIST_W'(int'(stream_q) * NUM_CLASSES + int'(sel_cls));
		list_base   = STORE_AW'(int'(list_idx) * LIST_DEPTH);
		store_waddr = list_base + STORE_AW'(sel_fill);
		store_raddr = list_base + STORE_AW'(sel_fill - FILL_W'(1));
	end

	// Operation decode on the fill row.
	always_comb begin
		new_fill = sel_fill;
		row_upd  = 1'b0;
		pop      = 1'b0;
		r_status = RS_HIT;
		r_bytes  = '0;
		misses_d = misses_q;
		unique case (op_q)
			OP_ALLOC: begin
				if (bytes_zero_q) begin
					r_status = RS_ZERO;
				end else if (!cls_ok_q) begin
					r_status = RS_TOO_LARGE;
				end else if (sel_fill != '0) begin
					r_status = RS_HIT;
					pop      = 1'b1;
					row_upd  = 1'b1;
					new_fill = sel_fill - FILL_W'(1);
				end else begin
					r_status = RS_MISS;
					r_bytes  = BYTES_W'(1) << cls_q;
					if (misses_q != MISS_MAX) begin
						misses_d = misses_q + MISS_W'(1);
					end
				end
			end
			OP_FREE: begin
				if (addr_q == '0) begin
					r_status = RS_NULL;
				end else if (!cls_ok_q) begin
					r_status = RS_TOO_LARGE;
				end else if (sel_fill >= FILL_FULL) begin
					r_status = RS_DROPPED;
				end else begin
					r_status = RS_STORED;
					row_upd  = 1'b1;
					new_fill = sel_fill + FILL_W'(1);
				end
			end
			OP_DRAIN: begin
				if (!drain_any_q) begin
					r_status = RS_EMPTY;
				end else begin
					r_status = RS_DRAINED;
					pop      = 1'b1;
					row_upd  = 1'b1;
					new_fill = sel_fill - FILL_W'(1);
					r_bytes  = BYTES_W'(1) << drain_cls;
				end
			end
			OP_MISS_CLR: begin
				r_status = RS_MISS_CLR;
				misses_d = '0;
			end
		endcase
		row_new = row_eff;
		row_new[int'(sel_cls)*FILL_W +: FILL_W] = new_fill;
		summary_d = summary_q;
		summary_d[stream_q] = |row_new;
	end

	// Sequencer state register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state, RAM strobes and output loading.
	always_comb begin
		state_d      = state_q;
		fill_we      = 1'b0;
		store_we     = 1'b0;
		store_re     = 1'b0;
		res_we       = 1'b0;
		res_addr_we  = 1'b0;
		res_addr_d   = '0;
		out_load     = 1'b0;
		out_status_d = res_status_q;
		out_addr_d   = res_addr_q;
		out_bytes_d  = res_bytes_q;
		out_miss_d   = misses_q;
		out_empty_d  = (summary_q == '0);
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					state_d = S_ROW;
				end
			end
			S_ROW: begin
				fill_we  = row_upd;
				store_we = row_upd && !pop;
				store_re = pop;
				if (pop) begin
					res_we  = 1'b1;
					state_d = S_POP;
				end else if (out_free) begin
					out_load     = 1'b1;
					out_status_d = r_status;
					out_addr_d   = '0;
					out_bytes_d  = r_bytes;
					out_miss_d   = misses_d;
					out_empty_d  = (summary_d == '0);
					state_d      = S_IDLE;
				end else begin
					res_we      = 1'b1;
					res_addr_we = 1'b1;
					state_d     = S_HOLD;
				end
			end
			S_POP: begin
				if (out_free) begin
					out_load   = 1'b1;
					out_addr_d = store_rdata;
					state_d    = S_IDLE;
				end else begin
					res_addr_we = 1'b1;
					res_addr_d  = store_rdata;
					state_d     = S_HOLD;
				end
			end
			S_HOLD: begin
				if (out_free) begin
					out_load = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Occupancy flags and miss counter change only when a fill row is processed.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			summary_q <= '0;
			misses_q  <= '0;
		end else if (state_q == S_ROW) begin
			if (fill_we) begin
				summary_q <= summary_d;
			end
			misses_q <= misses_d;
		end
	end

	// Parked result while the response word waits.
	always_ff @(posedge clk) begin
		if (res_we) begin
			res_status_q <= r_status;
			res_bytes_q  <= r_bytes;
		end
		if (res_addr_we) begin
			res_addr_q <= res_addr_d;
		end
	end

	// Output register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (out_load) begin
			out_status_q <= out_status_d;
			out_addr_q   <= out_addr_d;
			out_bytes_q  <= out_bytes_d;
			out_miss_q   <= out_miss_d;
			out_empty_q  <= out_empty_d;
		end
	end

	assign rsp.valid             = out_valid_q;
	assign rsp.status            = out_status_q;
	assign rsp.block_address_res = out_addr_q;
	assign rsp.alloc_bytes       = out_bytes_q;
	assign rsp.miss_count        = out_miss_q;
	assign rsp.cache_empty       = out_empty_q;

endmodule

`default_nettype wire

>>> design/scbc_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
`timescale 1ns / 1ps
`default_nettype none

module scbc_ram #(
	parameter int  WIDTH = 8,
	parameter int  DEPTH = 16,
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write and registered read; the read data holds until the next read.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire
